FILE: hw/rtl/tsps_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the tempo synced preset selector.
// No dependencies; every other file but tsps_stream_if imports this package.
package tsps_pkg;

	localparam int DEF_MAX_PRESETS = 256;

	localparam int DT_W       = 16;
	localparam int REQ_W      = 10;
	localparam int CNT_W      = 9;
	localparam int OUT_W      = 8;
	localparam int PER_W      = 18;
	localparam int ACC_W      = 19;
	localparam int SEED_W     = 32;
	localparam int GOTO_W     = 11;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COUNT  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SEED   = 3'd4;

	localparam logic [1:0] MODE_SEQ    = 2'd0;
	localparam logic [1:0] MODE_RANDOM = 2'd1;
	localparam logic [1:0] MODE_TEMPO  = 2'd2;

	localparam logic [GOTO_W-1:0] NO_GOTO      = 11'h7FF;
	localparam logic [DT_W-1:0]   DT_RESET     = 16'd1092;
	localparam logic [PER_W-1:0]  MIN_PERIOD   = 18'd4096;
	localparam logic [PER_W-1:0]  PERIOD_RESET = 18'd32768;
	localparam logic [SEED_W-1:0] LFSR_TAPS    = 32'h8020_0003;
	localparam logic [SEED_W-1:0] SEED_RESET   = 32'd1;

	typedef struct packed {
		logic [DT_W-1:0]  dt_ticks;
		logic [REQ_W-1:0] request_index;
		logic             next_level;
		logic             prev_level;
		logic             goto_valid;
		logic [REQ_W-1:0] goto_target;
	} frame_t;

	typedef struct packed {
		logic [OUT_W-1:0] current_index;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REQ,
		ST_EDGE_N,
		ST_EDGE_P,
		ST_MUL,
		ST_PICK,
		ST_GOTO,
		ST_ADD,
		ST_SUB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_req;
		logic do_edge;
		logic sel_prev;
		logic do_mul;
		logic do_pick;
		logic do_goto;
		logic do_add;
		logic do_sub;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic enable;
		logic next_pick;
		logic prev_pick;
		logic tempo;
		logic beat_due;
	} ctrl_stat_t;

endpackage

FILE: hw/rtl/tsps_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload of a chosen type.
// No dependencies.
interface tsps_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tsps_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the selector: walks one frame request through the rule steps.
// Depends on tsps_pkg for the state enum and the command/status structs.
module tsps_ctrl import tsps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				// drop requests while disabled
				if (in_valid && stat.enable) begin
					cmd.capture = 1'b1;
					state_d     = ST_REQ;
				end
			end
			ST_REQ: begin
				cmd.do_req = 1'b1;
				state_d    = ST_EDGE_N;
			end
			ST_EDGE_N: begin
				cmd.do_edge = 1'b1;
				phase_d     = 1'b0;
				state_d     = stat.next_pick ? ST_MUL : ST_EDGE_P;
			end
			ST_EDGE_P: begin
				cmd.do_edge  = 1'b1;
				cmd.sel_prev = 1'b1;
				phase_d      = 1'b1;
				state_d      = stat.prev_pick ? ST_MUL : ST_GOTO;
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = ST_PICK;
			end
			ST_PICK: begin
				cmd.do_pick = 1'b1;
				state_d     = phase_q ? ST_GOTO : ST_EDGE_P;
			end
			ST_GOTO: begin
				cmd.do_goto = 1'b1;
				state_d     = stat.tempo ? ST_ADD : ST_OUT;
			end
			ST_ADD: begin
				cmd.do_add = 1'b1;
				state_d    = ST_SUB;
			end
			ST_SUB: begin
				if (stat.beat_due) begin
					cmd.do_sub = 1'b1;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/tsps_dp.sv
`timescale 1ns / 1ps
// Datapath for the selector: configuration, index state, LFSR, pick multiplier
// and beat accumulator. Depends on tsps_pkg.
module tsps_dp import tsps_pkg::*; #(
	parameter int MAX_PRESETS = DEF_MAX_PRESETS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_stat_t            stat,
	input  frame_t                frame_data,
	input  logic                  cfg_wen,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output result_t               out_data
);

	localparam int IDX_W  = $clog2(MAX_PRESETS);
	localparam int CMP_W  = ((IDX_W > REQ_W) ? IDX_W : REQ_W) + 1;
	localparam int PROD_W = SEED_W + CNT_W;

	logic              en_q;
	logic [1:0]        mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PER_W-1:0]  period_q;

	logic [IDX_W-1:0]  idx_q;
	logic [REQ_W-1:0]  last_req_q;
	logic              last_next_q;
	logic              last_prev_q;
	logic [GOTO_W-1:0] last_goto_q;
	logic [DT_W-1:0]   last_dt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SEED_W-1:0] lfsr_q;
	logic              e_next_q;
	logic              e_prev_q;

	frame_t            in_q;
	logic [CNT_W-1:0]  pick_q;
	result_t           out_q;

	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  nm1;
	logic [CMP_W-1:0]  n_cmp;
	logic [CMP_W-1:0]  idx_cmp;
	logic              n_pos;
	logic              n_gt1;
	logic              random_mode;
	logic [CMP_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  idx_next;
	logic [IDX_W-1:0]  idx_prev;
	logic [IDX_W-1:0]  idx_req;
	logic [IDX_W-1:0]  idx_goto;
	logic              edge_sel;
	logic [SEED_W-1:0] lfsr_step;
	logic [PROD_W-1:0] prod;
	logic [PER_W-1:0]  period_eff;
	logic [DT_W-1:0]   dt_sel;

	always_comb begin
		n           = (int'(cnt_q) > MAX_PRESETS) ? CNT_W'(MAX_PRESETS) : cnt_q;
		nm1         = n - CNT_W'(1);
		n_cmp       = CMP_W'(n);
		idx_cmp     = CMP_W'(idx_q);
		n_pos       = (n != '0);
		n_gt1       = (n > CNT_W'(1));
		random_mode = (mode_q == MODE_RANDOM);

		idx_inc  = idx_cmp + CMP_W'(1);
		idx_next = (idx_inc == n_cmp) ? '0 : IDX_W'(idx_inc);
		idx_prev = (idx_q == '0) ? IDX_W'(nm1) : idx_q - IDX_W'(1);

		idx_req = (idx_cmp >= n_cmp) ? '0 : idx_q;
		if (in_q.request_index != last_req_q && n_pos &&
				CMP_W'(in_q.request_index) < n_cmp) begin
			idx_req = IDX_W'(in_q.request_index);
		end

		idx_goto = (CMP_W'(in_q.goto_target) < n_cmp) ? IDX_W'(in_q.goto_target)
		                                              : IDX_W'(nm1);

		edge_sel  = cmd.sel_prev ? e_prev_q : e_next_q;
		lfsr_step = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
		prod      = PROD_W'(lfsr_q) * PROD_W'(nm1);

		period_eff = (period_q < MIN_PERIOD) ? MIN_PERIOD : period_q;
		dt_sel     = (in_q.dt_ticks == '0) ? last_dt_q : in_q.dt_ticks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b1;
			mode_q      <= MODE_SEQ;
			cnt_q       <= '0;
			period_q    <= PERIOD_RESET;
			idx_q       <= '0;
			last_req_q  <= '0;
			last_next_q <= 1'b0;
			last_prev_q <= 1'b0;
			last_goto_q <= NO_GOTO;
			last_dt_q   <= DT_RESET;
			acc_q       <= '0;
			lfsr_q      <= SEED_RESET;
			e_next_q    <= 1'b0;
			e_prev_q    <= 1'b0;
		end else begin
			if (cmd.do_req) begin
				idx_q       <= idx_req;
				last_req_q  <= in_q.request_index;
				e_next_q    <= in_q.next_level & ~last_next_q;
				e_prev_q    <= in_q.prev_level & ~last_prev_q;
				last_next_q <= in_q.next_level;
				last_prev_q <= in_q.prev_level;
			end
			if (cmd.do_edge && edge_sel && n_pos) begin
				if (!random_mode) begin
					idx_q <= cmd.sel_prev ? idx_prev : idx_next;
				end else if (!n_gt1) begin
					idx_q <= '0;
				end else begin
					lfsr_q <= lfsr_step;
				end
			end
			if (cmd.do_pick) begin
				if (CMP_W'(pick_q) >= idx_cmp) begin
					idx_q <= IDX_W'(pick_q + CNT_W'(1));
				end else begin
					idx_q <= IDX_W'(pick_q);
				end
			end
			if (cmd.do_goto && in_q.goto_valid &&
					GOTO_W'(in_q.goto_target) != last_goto_q) begin
				if (n_pos) begin
					idx_q <= idx_goto;
				end
				last_goto_q <= GOTO_W'(in_q.goto_target);
			end
			if (cmd.do_add) begin
				if (in_q.dt_ticks != '0) begin
					last_dt_q <= in_q.dt_ticks;
				end
				acc_q <= acc_q + ACC_W'(dt_sel);
			end
			if (cmd.do_sub) begin
				acc_q <= acc_q - ACC_W'(period_eff);
				idx_q <= idx_next;
			end
			if (cfg_wen) begin
				case (cfg_addr)
					REG_ENABLE: en_q     <= cfg_wdata[0];
					REG_MODE:   mode_q   <= cfg_wdata[1:0];
					REG_COUNT:  cnt_q    <= cfg_wdata[CNT_W-1:0];
					REG_PERIOD: period_q <= cfg_wdata[PER_W-1:0];
					REG_SEED:   lfsr_q   <= (cfg_wdata[SEED_W-1:0] == '0) ? SEED_RESET
					                                                  : cfg_wdata[SEED_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= frame_data;
		end
		if (cmd.do_mul) begin
			pick_q <= prod[PROD_W-1:SEED_W];
		end
		if (cmd.load_out) begin
			out_q.current_index <= OUT_W'(idx_q);
		end
	end

	always_comb begin
		stat.enable    = en_q;
		stat.next_pick = e_next_q && n_pos && random_mode && n_gt1;
		stat.prev_pick = e_prev_q && n_pos && random_mode && n_gt1;
		stat.tempo     = (mode_q == MODE_TEMPO) && n_pos;
		stat.beat_due  = (acc_q >= ACC_W'(period_eff));
	end

	assign out_data = out_q;

endmodule

FILE: hw/rtl/tempo_synced_preset_selector.sv
`timescale 1ns / 1ps
// Tempo synced preset selector, top level. Depends on tsps_pkg, tsps_stream_if,
// tsps_ctrl and tsps_dp.
// Use: each request on the frame channel is one video frame tick. While enabled,
// the block applies the direct request, next/prev edges, goto and tempo advance
// in that order and returns the new index on the result channel; while disabled
// a request is taken and dropped with no result and no state change.
// Configuration goes through cfg_wen/cfg_addr/cfg_wdata; the user must write it
// only while idle, which the block itself does not enforce. A frame runs the
// request, edge and goto steps, a multiply and pick step per random pick, and in
// tempo mode an add step and a beat loop that subtracts one period per cycle.
// One frame is in work at a time; frame.ready is high only when idle.
// A stalled result holds in the output register; the next frame is accepted
// meanwhile and waits at its final step until the register frees.
// Reset clears index and accumulator, resets the history registers and loads
// the default configuration; the LFSR restarts at SEED_RESET.
module tempo_synced_preset_selector import tsps_pkg::*; #(
	parameter int MAX_PRESETS = DEF_MAX_PRESETS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tsps_stream_if.sink           frame,
	tsps_stream_if.source         result,
	input  logic                  cfg_wen,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	logic       in_ready;
	logic       out_valid;
	result_t    out_data;

	tsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame.valid),
		.in_ready  (in_ready),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsps_dp #(
		.MAX_PRESETS (MAX_PRESETS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.frame_data (frame.data),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_data   (out_data)
	);

	assign frame.ready  = in_ready;
	assign result.valid = out_valid;
	assign result.data  = out_data;

endmodule

FILE: hw/rtl/tsps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the preset selector, bound to the top level.
// Depends on tsps_pkg and tempo_synced_preset_selector.
module tsps_checker import tsps_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] out_index
);

	a_out_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index))
		else $error("stalled result changed or dropped");

	a_rise_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

	a_rise_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready, 4))
		else $error("result appeared too soon after a request");

endmodule

bind tempo_synced_preset_selector tsps_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame.valid),
	.in_ready  (frame.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_index (result.data.current_index)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tempo_synced_preset_selector: directed frames per rule,
// then random frame traffic over random settings, random frame gaps and result stalls.
// Depends on tsps_pkg, tsps_stream_if and the RTL of the selector.
module tb_top;
	import tsps_pkg::*;

	localparam logic [1:0] MODE_UNUSED     = 2'd3;
	localparam int         FRAME_TARGET    = 2000;
	localparam int         SETTLE_CYCLES   = 40;
	localparam int         WATCHDOG_LIMIT  = 4000;
	localparam int         MAX_PRINTS      = 30;

	logic clk;
	logic arst_n;
	logic                  cfg_wen;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tsps_stream_if #(.payload_t(frame_t))  frame_ch ();
	tsps_stream_if #(.payload_t(result_t)) result_ch ();

	tempo_synced_preset_selector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.result   (result_ch),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// selector settings and state as seen by the predictor
	logic              sel_enable = 1'b1;
	logic [1:0]        sel_mode   = MODE_SEQ;
	logic [CNT_W-1:0]  sel_count  = '0;
	logic [PER_W-1:0]  sel_period = PERIOD_RESET;
	logic [OUT_W-1:0]  cur_idx    = '0;
	logic [REQ_W-1:0]  last_req   = '0;
	logic              last_next  = 1'b0;
	logic              last_prev  = 1'b0;
	logic [GOTO_W-1:0] last_goto  = NO_GOTO;
	logic [DT_W-1:0]   last_dt    = DT_RESET;
	logic [ACC_W-1:0]  beat_acc   = '0;
	logic [SEED_W-1:0] lfsr_q     = SEED_RESET;

	result_t pending_index_q[$];
	result_t want;
	int      err_count;
	int      result_count;

	// frame generator history
	logic [REQ_W-1:0] tx_req;
	logic [REQ_W-1:0] tx_goto;
	logic             tx_next;
	logic             tx_prev;
	int               burst_left;
	bit               gaps_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned draw_other_preset(int unsigned n,
			int unsigned idx);
		longint unsigned prod;
		int unsigned     p;
		if (n <= 1)
			return 0;
		lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
		prod = 64'(lfsr_q) * 64'(n - 1);
		p = prod[63:32];
		if (p >= idx)
			p++;
		return p;
	endfunction

	function automatic void select_preset(frame_t f);
		int unsigned n, idx, dt, period, acc, k;
		logic        rising;
		if (!sel_enable)
			return;
		n = (sel_count > DEF_MAX_PRESETS) ? DEF_MAX_PRESETS : 32'(sel_count);
		idx = 32'(cur_idx);
		if (idx >= n)
			idx = 0;
		if (f.request_index != last_req) begin
			if (n > 0 && f.request_index < n)
				idx = 32'(f.request_index);
			last_req = f.request_index;
		end
		rising = f.next_level && !last_next;
		last_next = f.next_level;
		if (rising && n > 0)
			idx = (sel_mode == MODE_RANDOM) ? draw_other_preset(n, idx) : (idx + 1) % n;
		rising = f.prev_level && !last_prev;
		last_prev = f.prev_level;
		if (rising && n > 0)
			idx = (sel_mode == MODE_RANDOM) ? draw_other_preset(n, idx) : (idx + n - 1) % n;
		if (f.goto_valid && {1'b0, f.goto_target} != last_goto) begin
			if (n > 0)
				idx = (f.goto_target < n) ? 32'(f.goto_target) : n - 1;
			last_goto = {1'b0, f.goto_target};
		end
		if (sel_mode == MODE_TEMPO && n > 0) begin
			dt = 32'(f.dt_ticks);
			if (dt == 0)
				dt = 32'(last_dt);
			else
				last_dt = f.dt_ticks;
			period = 32'((sel_period < MIN_PERIOD) ? MIN_PERIOD : sel_period);
			acc = 32'(beat_acc) + dt;
			k = acc / period;
			acc = acc - k * period;
			beat_acc = ACC_W'(acc);
			idx = (idx + k) % n;
		end
		cur_idx = OUT_W'(idx);
		pending_index_q = {pending_index_q, result_t'(cur_idx)};
	endfunction

	always @(posedge clk)
		if (arst_n && frame_ch.valid && frame_ch.ready)
			select_preset(frame_ch.data);

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("%0t ns result %0d: %s, got %0d, expected %0d",
				$realtime, result_count, what, got, exp_val);
	endtask

	always @(posedge clk)
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_index_q.size() == 0) begin
				report_mismatch("result with no frame pending",
					int'(result_ch.data.current_index), -1);
			end else begin
				want = pending_index_q.pop_front();
				if (result_ch.data.current_index !== want.current_index)
					report_mismatch("current_index", int'(result_ch.data.current_index),
						int'(want.current_index));
			end
			result_count++;
		end

	// receiver: change stall style each time the 9-bit cycle counter wraps
	initial begin
		logic [8:0] rx_cycle;
		logic [1:0] rx_style;
		rx_cycle = '0;
		rx_style = 2'd0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == '0)
				rx_style = 2'($urandom_range(0, 3));
			case (rx_style)
				2'd0: result_ch.ready <= 1'b1;
				2'd1: result_ch.ready <= ($urandom_range(0, 3) != 0);
				2'd2: result_ch.ready <= ($urandom_range(0, 3) == 0);
				default: result_ch.ready <= (rx_cycle[4:0] < 5'd20);
			endcase
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tempo_synced_preset_selector verification failed");
		$finish;
	end

	task automatic send_frame(input frame_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
				if (gap > 0) begin
					frame_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		frame_ch.valid <= 1'b1;
		frame_ch.data  <= f;
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	task automatic stop_frames();
		frame_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	task automatic wait_results();
		while (pending_index_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		case (addr)
			REG_ENABLE: sel_enable = data[0];
			REG_MODE:   sel_mode   = data[1:0];
			REG_COUNT:  sel_count  = data[CNT_W-1:0];
			REG_PERIOD: sel_period = data[PER_W-1:0];
			REG_SEED:   lfsr_q     = (data == '0) ? 32'd1 : data;
			default: ;
		endcase
	endtask

	// drain, let dropped frames settle, then rewrite every register
	task automatic apply_config(input logic en, input logic [1:0] md,
			input logic [CNT_W-1:0] cnt, input logic [PER_W-1:0] per,
			input logic [SEED_W-1:0] seed);
		stop_frames();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_MODE, CFG_DATA_W'(md));
		write_reg(REG_COUNT, CFG_DATA_W'(cnt));
		write_reg(REG_PERIOD, CFG_DATA_W'(per));
		write_reg(REG_SEED, seed);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	function automatic frame_t frm(input logic [DT_W-1:0] dt, input logic [REQ_W-1:0] req,
			input logic nx, input logic pv, input logic gv, input logic [REQ_W-1:0] gt);
		frame_t f;
		f.dt_ticks      = dt;
		f.request_index = req;
		f.next_level    = nx;
		f.prev_level    = pv;
		f.goto_valid    = gv;
		f.goto_target   = gt;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t      f;
		int unsigned span, r;
		span = (sel_count == 0) ? 4 :
			((sel_count > DEF_MAX_PRESETS) ? DEF_MAX_PRESETS : 32'(sel_count));
		if ($urandom_range(0, 9) == 0) begin
			f = frm(DT_W'($urandom_range(0, 65535)), REQ_W'($urandom_range(0, 1023)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), REQ_W'($urandom_range(0, 1023)));
			return f;
		end
		r = $urandom_range(0, 9);
		if (r < 2)
			f.dt_ticks = '0;
		else if (r < 6)
			f.dt_ticks = DT_W'($urandom_range(1, 4096));
		else if (r == 9)
			f.dt_ticks = '1;
		else
			f.dt_ticks = DT_W'($urandom_range(0, 65535));
		if ($urandom_range(0, 3) == 0)
			tx_req = REQ_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
			                                            : $urandom_range(0, span - 1));
		if ($urandom_range(0, 3) == 0)
			tx_goto = REQ_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
			                                             : $urandom_range(0, span - 1));
		tx_next ^= ($urandom_range(0, 2) == 0);
		tx_prev ^= ($urandom_range(0, 2) == 0);
		f.request_index = tx_req;
		f.next_level    = tx_next;
		f.prev_level    = tx_prev;
		f.goto_valid    = ($urandom_range(0, 2) != 0);
		f.goto_target   = tx_goto;
		return f;
	endfunction

	task automatic test_empty_presets();
		send_frame(frm(16'd0, 10'd5, 1'b1, 1'b1, 1'b1, 10'd7));
		send_frame(frm(16'hFFFF, 10'h3FF, 1'b0, 1'b0, 1'b1, 10'h3FF));
	endtask

	task automatic test_sequential_rules();
		apply_config(1'b1, MODE_SEQ, 9'd5, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd1092, 10'd3, 1'b0, 1'b0, 1'b0, 10'd0));
		send_frame(frm(16'd1092, 10'd3, 1'b1, 1'b0, 1'b0, 10'd0));
		send_frame(frm(16'd1092, 10'd7, 1'b1, 1'b1, 1'b0, 10'd0));
		send_frame(frm(16'd1092, 10'd7, 1'b0, 1'b1, 1'b1, 10'd900));
		send_frame(frm(16'd1092, 10'd7, 1'b1, 1'b0, 1'b1, 10'd900));
		send_frame(frm(16'd1092, 10'd0, 1'b0, 1'b1, 1'b1, 10'd2));
		apply_config(1'b1, MODE_UNUSED, 9'd5, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd0, 10'd0, 1'b1, 1'b0, 1'b0, 10'd0));
	endtask

	task automatic test_random_picks();
		apply_config(1'b1, MODE_RANDOM, 9'd256, PERIOD_RESET, 32'd0);
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		send_frame(frm(16'd0, 10'd0, 1'b1, 1'b1, 1'b0, 10'd0));
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		apply_config(1'b1, MODE_RANDOM, 9'd2, PERIOD_RESET, 32'hFFFF_FFFF);
		send_frame(frm(16'd0, 10'd0, 1'b1, 1'b1, 1'b0, 10'd0));
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		apply_config(1'b1, MODE_RANDOM, 9'd1, PERIOD_RESET, 32'hFFFF_FFFF);
		send_frame(frm(16'd0, 10'd0, 1'b1, 1'b1, 1'b0, 10'd0));
	endtask

	task automatic test_tempo_advance();
		apply_config(1'b1, MODE_TEMPO, 9'd7, 18'd100, 32'd5);
		send_frame(frm(16'hFFFF, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		apply_config(1'b1, MODE_TEMPO, 9'd256, 18'h3FFFF, SEED_RESET);
		send_frame(frm(16'hFFFF, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b0, 10'd0));
	endtask

	task automatic test_disabled_frames();
		apply_config(1'b0, MODE_SEQ, 9'd5, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd9, 10'd4, 1'b1, 1'b1, 1'b1, 10'd3));
		send_frame(frm(16'd9, 10'd4, 1'b1, 1'b1, 1'b1, 10'd3));
		apply_config(1'b1, MODE_SEQ, 9'd5, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd0, 10'd4, 1'b1, 1'b1, 1'b1, 10'd3));
	endtask

	task automatic test_count_limits();
		apply_config(1'b1, MODE_SEQ, 9'd511, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd0, 10'd0, 1'b0, 1'b0, 1'b1, 10'd1000));
		send_frame(frm(16'd0, 10'd300, 1'b0, 1'b0, 1'b0, 10'd1000));
		apply_config(1'b1, MODE_SEQ, 9'd10, PERIOD_RESET, SEED_RESET);
		send_frame(frm(16'd0, 10'd300, 1'b0, 1'b0, 1'b0, 10'd1000));
	endtask

	task automatic test_random_traffic();
		int          counted, len, r;
		bit          paused;
		logic        en;
		logic [1:0]  md;
		logic [8:0]  cnt;
		logic [17:0] per;
		logic [31:0] seed;
		counted = 0;
		paused  = 1'b0;
		while (counted < FRAME_TARGET) begin
			en = ($urandom_range(0, 7) != 0);
			md = 2'($urandom_range(0, 3));
			r = $urandom_range(0, 7);
			case (r)
				0: cnt = 9'd0;
				1: cnt = 9'd1;
				2: cnt = 9'd2;
				3: cnt = 9'($urandom_range(3, 16));
				4: cnt = 9'($urandom_range(17, 255));
				5: cnt = 9'd256;
				6: cnt = 9'($urandom_range(257, 511));
				default: cnt = 9'($urandom_range(3, 8));
			endcase
			r = $urandom_range(0, 5);
			case (r)
				0: per = 18'($urandom_range(0, 4095));
				1: per = MIN_PERIOD;
				2: per = 18'h3FFFF;
				3: per = 18'($urandom_range(4096, 262143));
				default: per = 18'($urandom_range(4096, 20000));
			endcase
			r = $urandom_range(0, 5);
			seed = (r == 0) ? 32'd0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom);
			apply_config(en, md, cnt, per, seed);
			len = en ? $urandom_range(60, 200) : $urandom_range(5, 20);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < len; i++) begin
				if (i == len / 2 && (!paused || $urandom_range(0, 3) == 0)) begin
					stop_frames();
					wait_results();
					paused = 1'b1;
				end
				send_frame(random_frame());
			end
			if (en)
				counted += len;
		end
	endtask

	initial begin
		err_count    = 0;
		result_count = 0;
		burst_left   = 0;
		gaps_on      = 1'b1;
		tx_req       = '0;
		tx_goto      = '0;
		tx_next      = 1'b0;
		tx_prev      = 1'b0;
		arst_n          <= 1'b0;
		frame_ch.valid  <= 1'b0;
		frame_ch.data   <= '0;
		cfg_wen         <= 1'b0;
		cfg_addr        <= '0;
		cfg_wdata       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_presets();
		test_sequential_rules();
		test_random_picks();
		test_tempo_advance();
		test_disabled_frames();
		test_count_limits();
		test_random_traffic();

		stop_frames();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tempo_synced_preset_selector verification clean");
		else
			$display("tempo_synced_preset_selector verification failed");
		$finish;
	end

endmodule
